>>> src/cbf_pkg.sv
// package: types, constants and functions shared by the bloom filter modules
`default_nettype none
package cbf_pkg;

    localparam int unsigned FilterDepthDefault = 65536;
    localparam int unsigned MaxHashesDefault   = 16;

    localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
    localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
    localparam logic [63:0] MM_F1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MM_F2 = 64'hc4ceb9fe1a85ec53;

    localparam logic [1:0] REG_NUM_HASHES  = 2'd0;
    localparam logic [1:0] REG_MAX_COUNT   = 2'd1;
    localparam logic [1:0] REG_ACTIVE_SIZE = 2'd2;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [63:0] key;
    } cbf_in_t;

    typedef struct packed {
        logic [7:0] estimate;
        logic       present;
    } cbf_out_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [16:0] data;
    } cbf_cfg_t;

    // hash datapath micro operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,     // acc = key
        OP_MUL,      // product of acc and constant, one 16x64 slice per cycle
        OP_ROT,      // acc = rotl(acc,31)
        OP_INIT,     // h1 = acc ^ 8, h2 = 8, h1 += h2, h2 += h1
        OP_SEL1,     // acc = h1
        OP_SEL2,     // acc = h2
        OP_XS,       // acc ^= acc >> 33
        OP_PUT1,     // h1 = acc
        OP_PUT2,     // h2 = acc
        OP_FIN       // h1 += h2, h2 += h1, probe = h1
    } cbf_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_HASH,
        ST_MOD,
        ST_RD,
        ST_RDW,
        ST_RDACC,
        ST_DECIDE,
        ST_WR_MOD,
        ST_WR_RD,
        ST_WR_RDW,
        ST_WR_WR,
        ST_DONE
    } cbf_state_t;

    // controller to datapath
    typedef struct packed {
        cbf_op_t     op;
        logic [1:0]  cidx;      // constant select for multiply
        logic [1:0]  slice;     // multiplier slice
        logic        capture;   // latch input item
        logic        mod_start; // start modulo of current probe
        logic        probe_next;// probe += h2
        logic        probe_rst; // probe = h1
        logic        rd;        // read counter at index
        logic        acc_first; // reset counter accumulators
        logic        acc;       // accumulate counter value
        logic        wr;        // write incremented counter
        logic        clr_wr;    // clearing pass write
        logic        clr_rst;
        logic        emit;
    } cbf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mod_done;
        logic clr_last;
        logic insert_ok;
    } cbf_stat_t;

    function automatic logic [63:0] mm_const(input logic [1:0] sel);
        logic [63:0] c;
        unique case (sel)
            2'd0: c = MM_C1;
            2'd1: c = MM_C2;
            2'd2: c = MM_F1;
            default: c = MM_F2;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> src/cbf_ram.sv
// generic single port ram with registered read
`default_nettype none
module cbf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> src/cbf_datapath.sv
// datapath: hash registers, sliced multiplier, serial modulo, counter memory
`default_nettype none
module cbf_datapath #(
    parameter int unsigned FILTER_DEPTH = cbf_pkg::FilterDepthDefault
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cbf_pkg::cbf_cmd_t          cmd,
    input  wire cbf_pkg::cbf_in_t           item,
    input  wire logic [7:0]                 max_count,
    input  wire logic [16:0]                active_size,
    output cbf_pkg::cbf_stat_t              stat,
    output cbf_pkg::cbf_out_t               result
);
    import cbf_pkg::*;

    localparam int unsigned AW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int unsigned SW = $clog2(FILTER_DEPTH + 1) > 17 ? $clog2(FILTER_DEPTH + 1) : 17;
    localparam logic [SW-1:0] DepthConst = SW'(FILTER_DEPTH);

    logic        mode_reg;
    logic [63:0] key_reg;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] h1_reg, h1_next, h2_reg, h2_next;
    logic [63:0] probe_reg, probe_next;
    logic [SW-1:0] size_reg;
    // serial modulo: remainder and dividend shift
    logic [SW:0]   rem_reg;
    logic [63:0]   div_reg;
    logic [6:0]    mcnt_reg;
    logic [AW-1:0] idx_reg;
    logic [7:0]  lo_reg, hi_reg;
    logic        all_reg;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata;
    logic          ram_we;
    logic [SW-1:0] size_w;
    logic [SW:0]   rem_sh;
    logic [15:0]   mslice;
    logic [79:0]   pp;

    // effective modulus: 0 acts as 1, capped at depth
    always_comb
    begin
        size_w = SW'(active_size);
        if (active_size == 17'd0)
        begin
            size_w = SW'(1);
        end
        else if (SW'(active_size) > DepthConst)
        begin
            size_w = DepthConst;
        end
    end

    always_comb
    begin
        unique case (cmd.slice)
            2'd0: mslice = acc_reg[15:0];
            2'd1: mslice = acc_reg[31:16];
            2'd2: mslice = acc_reg[47:32];
            default: mslice = acc_reg[63:48];
        endcase
        pp = 80'(mslice) * 80'(mm_const(cmd.cidx));
    end

    always_comb
    begin
        acc_next  = acc_reg;
        prod_next = prod_reg;
        h1_next   = h1_reg;
        h2_next   = h2_reg;
        unique case (cmd.op)
            OP_LOAD: acc_next = key_reg;
            OP_MUL:
            begin
                prod_next = ((cmd.slice == 2'd0) ? 64'd0 : prod_reg)
                    + (pp[63:0] << {cmd.slice, 4'd0});
                if (cmd.slice == 2'd3)
                begin
                    acc_next = prod_next;
                end
            end
            OP_ROT:  acc_next = {acc_reg[32:0], acc_reg[63:33]};
            OP_INIT:
            begin
                h1_next = (acc_reg ^ 64'd8) + 64'd8;
                h2_next = h1_next + 64'd8;
            end
            OP_SEL1: acc_next = h1_reg;
            OP_SEL2: acc_next = h2_reg;
            OP_XS:   acc_next = acc_reg ^ (acc_reg >> 33);
            OP_PUT1: h1_next = acc_reg;
            OP_PUT2: h2_next = acc_reg;
            OP_FIN:
            begin
                h1_next = h1_reg + h2_reg;
                h2_next = h2_reg + h1_next;
            end
            default: ;
        endcase
    end

    // probe being set up this cycle, so a modulo started now sees it
    always_comb
    begin
        probe_next = probe_reg;
        if (cmd.probe_rst)
        begin
            probe_next = h1_next;
        end
        else if (cmd.probe_next)
        begin
            probe_next = probe_reg + h2_reg;
        end
    end

    assign rem_sh = {rem_reg[SW-1:0], div_reg[63]};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= item.mode;
            key_reg  <= item.key;
            size_reg <= size_w;
        end
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        h1_reg    <= h1_next;
        h2_reg    <= h2_next;
        probe_reg <= probe_next;
        if (cmd.mod_start)
        begin
            rem_reg <= '0;
            div_reg <= probe_next;
        end
        else if (!stat.mod_done)
        begin
            rem_reg <= (rem_sh >= {1'b0, size_reg}) ? rem_sh - {1'b0, size_reg} : rem_sh;
            div_reg <= {div_reg[62:0], 1'b0};
        end
        if (stat.mod_done)
        begin
            idx_reg <= AW'(rem_reg);
        end
        if (cmd.acc_first)
        begin
            lo_reg  <= max_count;
            hi_reg  <= 8'd0;
            all_reg <= 1'b1;
        end
        else if (cmd.acc)
        begin
            if (ram_rdata > hi_reg)
            begin
                hi_reg <= ram_rdata;
            end
            if (ram_rdata < lo_reg)
            begin
                lo_reg <= ram_rdata;
            end
            if (ram_rdata == 8'd0)
            begin
                all_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcnt_reg <= 7'd64;
            clr_reg  <= '0;
        end
        else
        begin
            if (cmd.mod_start)
            begin
                mcnt_reg <= 7'd0;
            end
            else if (mcnt_reg != 7'd64)
            begin
                mcnt_reg <= mcnt_reg + 7'd1;
            end
            if (cmd.clr_rst)
            begin
                clr_reg <= '0;
            end
            else if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    assign stat.mod_done  = (mcnt_reg == 7'd64) && !cmd.mod_start;
    assign stat.clr_last  = (clr_reg == AW'(FILTER_DEPTH - 1));
    assign stat.insert_ok = (hi_reg < max_count);

    always_comb
    begin
        ram_we    = cmd.wr || cmd.clr_wr;
        ram_addr  = cmd.clr_wr ? clr_reg : idx_reg;
        ram_wdata = cmd.clr_wr ? 8'd0
                  : ((ram_rdata == 8'hFF) ? 8'hFF : ram_rdata + 8'd1);
    end

    cbf_ram #(.WIDTH(8), .DEPTH(FILTER_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        result.estimate = 8'd0;
        result.present  = 1'b0;
        if (mode_reg == MODE_QUERY)
        begin
            result.present = all_reg;
        end
        else if (!stat.insert_ok)
        begin
            result.estimate = lo_reg;
        end
    end
endmodule
`default_nettype wire

>>> src/cbf_ctrl.sv
// controller: hash program sequencer and probe loop state machine
`default_nettype none
module cbf_ctrl #(
    parameter int unsigned MAX_HASHES = cbf_pkg::MaxHashesDefault
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [4:0]        num_hashes,
    input  wire cbf_pkg::cbf_stat_t stat,
    input  wire logic              mode_is_add,
    output logic                   busy,
    output cbf_pkg::cbf_cmd_t      cmd
);
    import cbf_pkg::*;

    localparam int unsigned NW = $clog2(MAX_HASHES + 1) > 5 ? $clog2(MAX_HASHES + 1) : 5;
    localparam logic [NW-1:0] MaxN = NW'(MAX_HASHES);
    localparam logic [5:0] PcLast = 6'd37;

    cbf_state_t state_reg, state_next;
    logic [5:0]    pc_reg, pc_next;
    logic [NW-1:0] n_reg, n_next, i_reg, i_next;
    logic [NW-1:0] n_eff;

    always_comb
    begin
        n_eff = (NW'(num_hashes) > MaxN) ? MaxN : NW'(num_hashes);
    end

    // hash program: one micro op per step
    function automatic cbf_cmd_t prog(input logic [5:0] pc);
        cbf_cmd_t c;
        logic [5:0] r;
        c = '0;
        c.op = OP_NONE;
        r = '0;
        priority if (pc == 6'd0)
        begin
            c.op = OP_LOAD;
        end
        else if (pc <= 6'd4)
        begin
            c.op = OP_MUL; c.cidx = 2'd0; c.slice = 2'(pc - 6'd1);
        end
        else if (pc == 6'd5)
        begin
            c.op = OP_ROT;
        end
        else if (pc <= 6'd9)
        begin
            c.op = OP_MUL; c.cidx = 2'd1; c.slice = 2'(pc - 6'd6);
        end
        else if (pc == 6'd10)
        begin
            c.op = OP_INIT;
        end
        else if (pc == 6'd11 || pc == 6'd24)
        begin
            c.op = (pc == 6'd11) ? OP_SEL1 : OP_SEL2;
        end
        else if (pc == 6'd23 || pc == 6'd36)
        begin
            c.op = (pc == 6'd23) ? OP_PUT1 : OP_PUT2;
        end
        else if (pc == 6'd37)
        begin
            c.op = OP_FIN; c.probe_rst = 1'b1;
        end
        else
        begin
            // mix body: xs, mul f1 x4, xs, mul f2 x4, xs  (11 steps)
            r = (pc > 6'd24) ? pc - 6'd25 : pc - 6'd12;
            priority if (r == 6'd0 || r == 6'd5 || r == 6'd10)
            begin
                c.op = OP_XS;
            end
            else if (r <= 6'd4)
            begin
                c.op = OP_MUL; c.cidx = 2'd2; c.slice = 2'(r - 6'd1);
            end
            else
            begin
                c.op = OP_MUL; c.cidx = 2'd3; c.slice = 2'(r - 6'd6);
            end
        end
        return c;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            pc_reg    <= '0;
            n_reg     <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_HASH;
                    pc_next    = '0;
                    n_next     = n_eff;
                end
            end
            ST_HASH:
            begin
                pc_next = pc_reg + 6'd1;
                if (pc_reg == PcLast)
                begin
                    i_next     = '0;
                    state_next = (n_reg == '0) ? ST_DECIDE : ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (stat.mod_done)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:     state_next = ST_RDW;
            ST_RDW:    state_next = ST_RDACC;
            ST_RDACC:
            begin
                i_next     = i_reg + NW'(1);
                state_next = (i_reg + NW'(1) == n_reg) ? ST_DECIDE : ST_MOD;
            end
            ST_DECIDE:
            begin
                i_next = '0;
                state_next = (mode_is_add && stat.insert_ok && n_reg != '0)
                           ? ST_WR_MOD : ST_DONE;
            end
            ST_WR_MOD:
            begin
                if (stat.mod_done)
                begin
                    state_next = ST_WR_RD;
                end
            end
            ST_WR_RD:  state_next = ST_WR_RDW;
            ST_WR_RDW: state_next = ST_WR_WR;
            ST_WR_WR:
            begin
                i_next     = i_reg + NW'(1);
                state_next = (i_reg + NW'(1) == n_reg) ? ST_DONE : ST_WR_MOD;
            end
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        cmd.op = OP_NONE;
        busy = 1'b1;
        unique case (state_reg)
            ST_CLEAR: cmd.clr_wr = 1'b1;
            ST_IDLE:
            begin
                busy          = 1'b0;
                cmd.capture   = start;
                cmd.acc_first = start;
            end
            ST_HASH:
            begin
                cmd = prog(pc_reg);
                cmd.mod_start = (pc_reg == PcLast) && (n_reg != '0);
            end
            ST_RDACC:
            begin
                cmd.acc        = 1'b1;
                cmd.probe_next = 1'b1;
                cmd.mod_start  = (i_reg + NW'(1) != n_reg);
            end
            ST_DECIDE:
            begin
                // rewind to the first probe and start its modulo for the writes
                cmd.probe_rst = 1'b1;
                cmd.op        = OP_NONE;
                cmd.mod_start = mode_is_add && stat.insert_ok && (n_reg != '0);
            end
            ST_WR_WR:
            begin
                cmd.wr         = 1'b1;
                cmd.probe_next = 1'b1;
                cmd.mod_start  = (i_reg + NW'(1) != n_reg);
            end
            ST_DONE:
            begin
                cmd.emit    = 1'b1;
                cmd.clr_rst = 1'b1;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

>>> src/counting_bloom_filter_core.sv
// top level of the counting bloom filter core
`default_nettype none
// counting bloom filter over 64-bit keys. after reset the core runs a clearing
// pass over the counter memory, one counter per cycle (FILTER_DEPTH counters,
// 65536 by default) and holds busy high meanwhile; configuration writes are
// taken at any time. an item is accepted when start is high and busy is low;
// one result comes back per item on result with done high for one cycle, and
// the receiver must take it then. an item is first hashed (a sliced 16x64
// multiplier runs the murmur3 mix), then each probe takes a bit-serial modulo
// and a read of the single-port counter memory; an add that inserts repeats
// the modulo and a read-modify-write per probe. the core takes no new item
// until it is through with the last one
module counting_bloom_filter_core #(
    parameter int unsigned FILTER_DEPTH = cbf_pkg::FilterDepthDefault,
    parameter int unsigned MAX_HASHES   = cbf_pkg::MaxHashesDefault
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire cbf_pkg::cbf_in_t  item,
    output logic                   done,
    output cbf_pkg::cbf_out_t      result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [16:0]       cfg_data
);
    import cbf_pkg::*;

    cbf_cmd_t  cmd;
    cbf_stat_t stat;
    cbf_out_t  res_w;

    logic [4:0]  num_hashes_reg;
    logic [7:0]  max_count_reg;
    logic [16:0] active_size_reg;
    logic        mode_reg;

    // configuration is always ready; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_hashes_reg  <= 5'd3;
            max_count_reg   <= 8'd255;
            active_size_reg <= 17'd65536;
            mode_reg        <= MODE_ADD;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_NUM_HASHES:  num_hashes_reg  <= cfg_data[4:0];
                    REG_MAX_COUNT:   max_count_reg   <= cfg_data[7:0];
                    REG_ACTIVE_SIZE: active_size_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.capture)
            begin
                mode_reg <= item.mode;
            end
        end
    end

    cbf_ctrl #(.MAX_HASHES(MAX_HASHES)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .num_hashes  (num_hashes_reg),
        .stat        (stat),
        .mode_is_add (mode_reg == MODE_ADD),
        .busy        (busy),
        .cmd         (cmd)
    );

    cbf_datapath #(.FILTER_DEPTH(FILTER_DEPTH)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .item        (item),
        .max_count   (max_count_reg),
        .active_size (active_size_reg),
        .stat        (stat),
        .result      (res_w)
    );

    // result is valid with done and holds until the next item is accepted
    assign done   = cmd.emit;
    assign result = res_w;

    // a result never carries both an estimate and a present flag
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.estimate == 8'd0 || !result.present))
        else $error("estimate and present both set");

    // done is a single-cycle pulse
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // an accepted item keeps the core busy the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after transfer");
endmodule
`default_nettype wire
